// File: hdl/sold_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sold_pkg
// Shared codes, widths and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package sold_pkg;

    localparam logic [1:0] KIND_MATRIX  = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_DECODE  = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    localparam logic [1:0] OP_POST = 2'd0;
    localparam logic [1:0] OP_SYN  = 2'd1;
    localparam logic [1:0] OP_CHK1 = 2'd2;
    localparam logic [1:0] OP_CHK2 = 2'd3;

    localparam logic [1:0] CFG_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_MAX_ITER = 2'd1;

    localparam int LLR_W    = 12;
    localparam int OUT_W    = 13;
    localparam int OFF_W    = 4;
    localparam int ITER_W   = 6;
    localparam int TB_W     = 10;
    localparam int TB_MAX   = 1023;
    localparam int OUT_MAX  = 4095;
    localparam int OUT_MIN  = -4096;
    localparam int CFG_W    = 6;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       first;
        logic       last;
        logic       pass_start;
        logic       zero;
        logic       fin;
    } t_cmd;

endpackage

// File: hdl/sold_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sold_ctrl
// Decode sequencer: walks the edge passes of each flooding iteration.
// ----------------------------------------------------------------------------
module sold_ctrl import sold_pkg::*; #(
    parameter int NUM_VARS   = 128,
    parameter int NUM_CHECKS = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start_dec,
    input  logic [ITER_W-1:0]                            i_max_iter,
    input  logic                                         i_fail,
    output logic                                         o_busy,
    output t_cmd                                         o_cmd,
    output logic [$clog2(NUM_CHECKS)-1:0]                o_c,
    output logic [(($clog2(NUM_VARS) > 7) ? $clog2(NUM_VARS) : 7)-1:0] o_n,
    output logic [(($clog2(NUM_VARS) > 7) ? $clog2(NUM_VARS) : 7)-7:0] o_seg,
    output logic [ITER_W-1:0]                            o_it
);

    localparam int N_W   = $clog2(NUM_VARS);
    localparam int CW    = (N_W > 7) ? N_W : 7;
    localparam int SEG_W = CW - 6;
    localparam int C_W   = $clog2(NUM_CHECKS);
    localparam int NSEG  = (NUM_VARS + 63) / 64;

    localparam logic [C_W-1:0]   C_LAST   = C_W'(NUM_CHECKS - 1);
    localparam logic [CW-1:0]    N_LAST   = CW'(NUM_VARS - 1);
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(NSEG - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POST   = 4'd1;
    localparam logic [3:0] S_POST_W = 4'd2;
    localparam logic [3:0] S_SYN    = 4'd3;
    localparam logic [3:0] S_SYN_W  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_CHK1   = 4'd6;
    localparam logic [3:0] S_CHK1_W = 4'd7;
    localparam logic [3:0] S_CHK2   = 4'd8;
    localparam logic [3:0] S_CHK2_W = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [C_W-1:0]    r_c, n_c;
    logic [CW-1:0]     r_n, n_n;
    logic [SEG_W-1:0]  r_seg, n_seg;
    logic [ITER_W-1:0] r_it, n_it;
    logic              r_zero, n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= '0;
            r_n     <= '0;
            r_seg   <= '0;
            r_it    <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_n     <= n_n;
            r_seg   <= n_seg;
            r_it    <= n_it;
            r_zero  <= n_zero;
        end
    end

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_n     = r_n;
        n_seg   = r_seg;
        n_it    = r_it;
        n_zero  = r_zero;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start_dec) begin
                    n_it    = '0;
                    n_zero  = 1'b1;
                    n_c     = '0;
                    n_n     = '0;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = OP_POST;
                o_cmd.first = (r_c == '0);
                o_cmd.last  = (r_c == C_LAST);
                o_cmd.zero  = r_zero;
                if (r_c == C_LAST) begin
                    n_c = '0;
                    if (r_n == N_LAST) begin
                        n_n     = '0;
                        n_state = S_POST_W;
                    end else begin
                        n_n = r_n + 1'b1;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            S_POST_W: begin
                n_c     = '0;
                n_seg   = '0;
                n_state = S_SYN;
            end
            S_SYN: begin
                o_cmd.valid      = 1'b1;
                o_cmd.op         = OP_SYN;
                o_cmd.first      = (r_seg == '0);
                o_cmd.last       = (r_seg == SEG_LAST);
                o_cmd.pass_start = (r_c == '0) && (r_seg == '0);
                if (r_seg == SEG_LAST) begin
                    n_seg = '0;
                    if (r_c == C_LAST) begin
                        n_c     = '0;
                        n_state = S_SYN_W;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end else begin
                    n_seg = r_seg + 1'b1;
                end
            end
            S_SYN_W: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_fail || (r_it == i_max_iter)) begin
                    n_state = S_FIN;
                end else begin
                    n_it    = r_it + 1'b1;
                    n_c     = '0;
                    n_n     = '0;
                    n_state = S_CHK1;
                end
            end
            S_CHK1: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = OP_CHK1;
                o_cmd.first = (r_n == '0);
                o_cmd.last  = (r_n == N_LAST);
                o_cmd.zero  = r_zero;
                if (r_n == N_LAST) begin
                    n_n     = '0;
                    n_state = S_CHK1_W;
                end else begin
                    n_n = r_n + 1'b1;
                end
            end
            S_CHK1_W: begin
                n_state = S_CHK2;
            end
            S_CHK2: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = OP_CHK2;
                o_cmd.first = (r_n == '0);
                o_cmd.last  = (r_n == N_LAST);
                o_cmd.zero  = r_zero;
                if (r_n == N_LAST) begin
                    n_n     = '0;
                    n_state = S_CHK2_W;
                end else begin
                    n_n = r_n + 1'b1;
                end
            end
            S_CHK2_W: begin
                if (r_c == C_LAST) begin
                    n_c     = '0;
                    n_zero  = 1'b0;
                    n_state = S_POST;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_CHK1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_c    = r_c;
    assign o_n    = r_n;
    assign o_seg  = (r_state == S_SYN) ? r_seg : r_n[CW-1:6];
    assign o_it   = r_it;

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_it <= i_max_iter))
        else $error("iteration count past limit");

    a_start_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start_dec) |=> (r_state == S_POST && r_zero))
        else $error("decode did not open with posterior pass");

    a_zero_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK1 && r_it > 6'd1) |-> !r_zero)
        else $error("message clear flag stuck after first iteration");

endmodule

// File: hdl/sold_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sold_dp
// Datapath: matrix, channel, message and posterior memories, edge stage
// and result register.
// ----------------------------------------------------------------------------
module sold_dp import sold_pkg::*; #(
    parameter int NUM_VARS   = 128,
    parameter int NUM_CHECKS = 64,
    parameter int STREAM_LEN = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_accept,
    input  logic [1:0]                                   i_kind,
    input  logic [5:0]                                   i_row_index,
    input  logic [6:0]                                   i_position,
    input  logic [63:0]                                  i_segment_bits,
    input  logic signed [LLR_W-1:0]                      i_channel_llr,
    input  logic [OFF_W-1:0]                             i_offset,
    input  t_cmd                                         i_cmd,
    input  logic [$clog2(NUM_CHECKS)-1:0]                i_c,
    input  logic [(($clog2(NUM_VARS) > 7) ? $clog2(NUM_VARS) : 7)-1:0] i_n,
    input  logic [(($clog2(NUM_VARS) > 7) ? $clog2(NUM_VARS) : 7)-7:0] i_seg,
    input  logic [ITER_W-1:0]                            i_it,
    output logic                                         o_fail,
    output logic                                         o_done,
    output logic                                         o_status,
    output logic                                         o_converged,
    output logic [ITER_W-1:0]                            o_iterations_used,
    output logic [TB_W-1:0]                              o_total_bits,
    output logic signed [OUT_W-1:0]                      o_llr_out,
    output logic                                         o_hard_bit
);

    localparam int N_W   = $clog2(NUM_VARS);
    localparam int CW    = (N_W > 7) ? N_W : 7;
    localparam int SEG_W = CW - 6;
    localparam int C_W   = $clog2(NUM_CHECKS);
    localparam int NSEG  = (NUM_VARS + 63) / 64;
    localparam int MAG_W = $clog2(STREAM_LEN + 1);
    localparam int TW_R  = $clog2(2048 + NUM_CHECKS * STREAM_LEN) + 1;
    localparam int TW    = (TW_R > OUT_W) ? TW_R : OUT_W;
    localparam int VW    = TW + 1;
    localparam int DV    = 64 * (2 ** SEG_W);

    localparam logic signed [TW-1:0] P_MAX = TW'(OUT_MAX);
    localparam logic signed [TW-1:0] P_MIN = TW'(OUT_MIN);

    logic [63:0]            m_h   [NUM_CHECKS * (2 ** SEG_W)];
    logic [MAG_W:0]         m_msg [NUM_CHECKS * (2 ** N_W)];
    logic signed [TW-1:0]   m_tot [NUM_VARS];
    logic signed [LLR_W-1:0] m_chan [NUM_VARS];

    logic [63:0]             r_h_word;
    logic [MAG_W:0]          r_msg_rd;
    logic signed [TW-1:0]    r_tot_rd;
    logic signed [LLR_W-1:0] r_chan_rd;

    t_cmd             r_s1;
    logic [C_W-1:0]   r_s1_c;
    logic [CW-1:0]    r_s1_n;
    logic [SEG_W-1:0] r_s1_seg;

    logic signed [TW-1:0] r_acc;
    logic                 r_par;
    logic                 r_fail;
    logic [MAG_W-1:0]     r_m1, r_m2;
    logic [N_W-1:0]       r_arg;
    logic                 r_argv;
    logic [NUM_VARS-1:0]  r_dec;

    logic                    r_done, r_status, r_conv, r_rd;
    logic [ITER_W-1:0]       r_iter;
    logic [TB_W-1:0]         r_tb;

    logic                 var_ok, mat_ok;
    logic [N_W-1:0]       tot_ra;
    logic [MAG_W-1:0]     levels;
    logic                 h_bit;
    logic [TW-1:0]        mag_ext;
    logic signed [TW-1:0] msg_val;
    logic signed [TW-1:0] acc_in, acc_nx;
    logic [DV-1:0]        dec_pad;
    logic                 syn_par;
    logic signed [VW-1:0] v;
    logic [VW-1:0]        v_abs, v_sat;
    logic [MAG_W-1:0]     k;
    logic                 v_neg;
    logic [MAG_W-1:0]     b_m1, b_m2, nx_m1, nx_m2;
    logic [N_W-1:0]       nx_arg;
    logic                 b_par, b_argv, nx_par, nx_argv;
    logic [MAG_W-1:0]     k_out;
    logic signed [TW-1:0] tot_clamp;
    int                   prod;

    assign var_ok = (int'(i_position) < NUM_VARS);
    assign mat_ok = (int'(i_row_index) < NUM_CHECKS) && (int'(i_position) < NSEG);
    assign tot_ra = i_cmd.valid ? i_n[N_W-1:0] : N_W'(i_position);
    assign levels = (int'(i_offset) < STREAM_LEN) ?
                    MAG_W'(STREAM_LEN - int'(i_offset)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_accept && i_kind == KIND_MATRIX && mat_ok) begin
            m_h[{C_W'(i_row_index), SEG_W'(i_position)}] <= i_segment_bits;
        end
        r_h_word <= m_h[{i_c, i_seg}];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_kind == KIND_CHANNEL && var_ok) begin
            m_chan[N_W'(i_position)] <= i_channel_llr;
        end
        r_chan_rd <= m_chan[i_n[N_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid && r_s1.op == OP_CHK2 && h_bit) begin
            m_msg[{r_s1_c, r_s1_n[N_W-1:0]}] <= {r_par ^ v_neg, k_out};
        end
        r_msg_rd <= m_msg[{i_c, i_n[N_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid && r_s1.op == OP_POST && r_s1.last) begin
            m_tot[r_s1_n[N_W-1:0]] <= acc_nx;
        end
        r_tot_rd <= m_tot[tot_ra];
    end

    always_comb begin
        h_bit   = r_h_word[r_s1_n[5:0]];
        mag_ext = {{(TW - MAG_W){1'b0}}, r_msg_rd[MAG_W-1:0]};
        if (r_s1.zero) begin
            msg_val = '0;
        end else if (r_msg_rd[MAG_W]) begin
            msg_val = -$signed(mag_ext);
        end else begin
            msg_val = $signed(mag_ext);
        end
        acc_in  = r_s1.first ? TW'(r_chan_rd) : r_acc;
        acc_nx  = h_bit ? (acc_in + msg_val) : acc_in;
        dec_pad = {{(DV - NUM_VARS){1'b0}}, r_dec};
        syn_par = ^(r_h_word & dec_pad[{r_s1_seg, 6'd0} +: 64]);
        v       = VW'(r_tot_rd) - VW'(msg_val);
        v_neg   = v[VW-1];
        v_abs   = v_neg ? VW'(-v) : VW'(v);
        v_sat   = (v_abs > VW'(STREAM_LEN)) ? VW'(STREAM_LEN) : v_abs;
        k       = (v_sat > VW'(i_offset)) ? MAG_W'(v_sat - VW'(i_offset)) : '0;
        b_m1    = r_s1.first ? levels : r_m1;
        b_m2    = r_s1.first ? levels : r_m2;
        b_par   = r_s1.first ? 1'b0 : r_par;
        b_argv  = r_s1.first ? 1'b0 : r_argv;
        nx_m1   = b_m1;
        nx_m2   = b_m2;
        nx_par  = b_par;
        nx_argv = b_argv;
        nx_arg  = r_arg;
        if (h_bit) begin
            nx_par = b_par ^ v_neg;
            if (k < b_m1) begin
                nx_m2   = b_m1;
                nx_m1   = k;
                nx_arg  = r_s1_n[N_W-1:0];
                nx_argv = 1'b1;
            end else if (k < b_m2) begin
                nx_m2 = k;
            end
        end
        k_out = (r_argv && r_arg == r_s1_n[N_W-1:0]) ? r_m2 : r_m1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= '0;
            r_fail <= 1'b0;
            r_dec  <= '0;
        end else begin
            r_s1 <= i_cmd;
            if (r_s1.valid) begin
                case (r_s1.op)
                    OP_POST: begin
                        if (r_s1.last) begin
                            r_dec[r_s1_n[N_W-1:0]] <= acc_nx[TW-1];
                        end
                    end
                    OP_SYN: begin
                        r_fail <= (r_s1.pass_start ? 1'b0 : r_fail) |
                                  (r_s1.last & ((r_s1.first ? 1'b0 : r_par) ^ syn_par));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_c   <= i_c;
        r_s1_n   <= i_n;
        r_s1_seg <= i_seg;
        if (r_s1.valid) begin
            case (r_s1.op)
                OP_POST: r_acc <= acc_nx;
                OP_SYN:  r_par <= (r_s1.first ? 1'b0 : r_par) ^ syn_par;
                OP_CHK1: begin
                    r_m1   <= nx_m1;
                    r_m2   <= nx_m2;
                    r_par  <= nx_par;
                    r_arg  <= nx_arg;
                    r_argv <= nx_argv;
                end
                default: begin
                end
            endcase
        end
    end

    assign prod = int'(i_it) * int'(levels);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_rd   <= 1'b0;
        end else if (i_accept && i_kind != KIND_DECODE) begin
            r_done   <= 1'b1;
            r_status <= (i_kind == KIND_MATRIX) ? !mat_ok : !var_ok;
            r_rd     <= (i_kind == KIND_READ) && var_ok;
            r_conv   <= 1'b0;
            r_iter   <= '0;
            r_tb     <= '0;
        end else if (i_cmd.fin) begin
            r_done   <= 1'b1;
            r_status <= 1'b0;
            r_rd     <= 1'b0;
            r_conv   <= !r_fail;
            r_iter   <= i_it;
            r_tb     <= (prod > TB_MAX) ? TB_W'(TB_MAX) : TB_W'(prod);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_comb begin
        if (r_tot_rd > P_MAX) begin
            tot_clamp = P_MAX;
        end else if (r_tot_rd < P_MIN) begin
            tot_clamp = P_MIN;
        end else begin
            tot_clamp = r_tot_rd;
        end
    end

    assign o_fail            = r_fail;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_converged       = r_conv;
    assign o_iterations_used = r_iter;
    assign o_total_bits      = r_tb;
    assign o_llr_out         = r_rd ? tot_clamp[OUT_W-1:0] : '0;
    assign o_hard_bit        = r_rd & r_tot_rd[TW-1];

endmodule

// File: hdl/stochastic_offset_min_sum_ldpc_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stochastic_offset_min_sum_ldpc_decoder
// Flooding offset min-sum LDPC decoder with thermometer-coded messages.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/busy; a transaction happens when start is high and
//   busy is low. kind selects matrix segment write, channel LLR write,
//   decode, or posterior read. Each item gives one result, shown for one
//   cycle with o_done high; the receiver cannot stall it.
//   Matrix, channel and read items: result in the cycle after acceptance, one
//   item per cycle, busy stays low.
//   Decode: busy high until done. The result follows the edge walk, one
//   matrix/message memory access per cycle: a posterior pass, a syndrome pass,
//   then per iteration two variable passes for each check, a posterior and a
//   syndrome pass.
//   Configuration: i_cfg_valid/o_cfg_ready, index 0 offset, 1 iteration
//   limit; write only while idle.
//   Reset (synchronous, i_rst_n low): controller idles, offset 2, limit 20,
//   decision bits cleared; memories keep content until written.
// ----------------------------------------------------------------------------
module stochastic_offset_min_sum_ldpc_decoder import sold_pkg::*; #(
    parameter int NUM_VARS   = 128,
    parameter int NUM_CHECKS = 64,
    parameter int STREAM_LEN = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_kind,
    input  logic [5:0]              i_row_index,
    input  logic [6:0]              i_position,
    input  logic [63:0]             i_segment_bits,
    input  logic signed [LLR_W-1:0] i_channel_llr,
    output logic                    o_done,
    output logic                    o_status,
    output logic                    o_converged,
    output logic [ITER_W-1:0]       o_iterations_used,
    output logic [TB_W-1:0]         o_total_bits,
    output logic signed [OUT_W-1:0] o_llr_out,
    output logic                    o_hard_bit,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int N_W   = $clog2(NUM_VARS);
    localparam int CW    = (N_W > 7) ? N_W : 7;
    localparam int SEG_W = CW - 6;
    localparam int C_W   = $clog2(NUM_CHECKS);

    logic [OFF_W-1:0]  r_offset;
    logic [ITER_W-1:0] r_max_iter;
    logic              accept;
    logic              fail;
    t_cmd              cmd;
    logic [C_W-1:0]    c_idx;
    logic [CW-1:0]     n_idx;
    logic [SEG_W-1:0]  seg_idx;
    logic [ITER_W-1:0] it;

    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= 4'd2;
            r_max_iter <= 6'd20;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OFFSET:   r_offset   <= i_cfg_data[OFF_W-1:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sold_ctrl #(
        .NUM_VARS   (NUM_VARS),
        .NUM_CHECKS (NUM_CHECKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_dec (accept && i_kind == KIND_DECODE),
        .i_max_iter  (r_max_iter),
        .i_fail      (fail),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_c         (c_idx),
        .o_n         (n_idx),
        .o_seg       (seg_idx),
        .o_it        (it)
    );

    sold_dp #(
        .NUM_VARS   (NUM_VARS),
        .NUM_CHECKS (NUM_CHECKS),
        .STREAM_LEN (STREAM_LEN)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_kind            (i_kind),
        .i_row_index       (i_row_index),
        .i_position        (i_position),
        .i_segment_bits    (i_segment_bits),
        .i_channel_llr     (i_channel_llr),
        .i_offset          (r_offset),
        .i_cmd             (cmd),
        .i_c               (c_idx),
        .i_n               (n_idx),
        .i_seg             (seg_idx),
        .i_it              (it),
        .o_fail            (fail),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_converged       (o_converged),
        .o_iterations_used (o_iterations_used),
        .o_total_bits      (o_total_bits),
        .o_llr_out         (o_llr_out),
        .o_hard_bit        (o_hard_bit)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flooding offset min-sum LDPC decoder. A
// behavioral decoder model tracks matrix, channel and posterior contents and
// predicts each result; a monitor compares every o_done strobe in order.
// ----------------------------------------------------------------------------
module tb;
    import sold_pkg::*;

    localparam int NV = 128;
    localparam int NC = 64;
    localparam int SL = 16;

    typedef struct packed {
        logic                    status;
        logic                    converged;
        logic [ITER_W-1:0]       iters;
        logic [TB_W-1:0]         total;
        logic signed [OUT_W-1:0] llr;
        logic                    hard;
    } t_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_kind;
    logic [5:0]              i_row_index;
    logic [6:0]              i_position;
    logic [63:0]             i_segment_bits;
    logic signed [LLR_W-1:0] i_channel_llr;
    logic                    o_done;
    logic                    o_status;
    logic                    o_converged;
    logic [ITER_W-1:0]       o_iterations_used;
    logic [TB_W-1:0]         o_total_bits;
    logic signed [OUT_W-1:0] o_llr_out;
    logic                    o_hard_bit;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    stochastic_offset_min_sum_ldpc_decoder dut (.*);

    // decoder model state
    bit      h_bit [NC][NV];
    int      chan_llr [NV];
    int      c2v_msg [NC][NV];
    int      v2c_cnt [NC][NV];
    bit      v2c_neg [NC][NV];
    int      post_llr [NV];
    bit      dec_bit [NV];
    int      cfg_offset;
    int      cfg_max_iter;

    t_result pending_results[$];
    int      errors;
    int      n_items;
    int      n_decodes;
    int      n_converged;
    int      n_iters;
    int      idle_pct;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    function automatic int thermo(int v);
        int a;
        a = (v < 0) ? -v : v;
        if (a > SL) a = SL;
        return (a > cfg_offset) ? a - cfg_offset : 0;
    endfunction

    function automatic bit checks_met();
        bit p;
        for (int c = 0; c < NC; c++) begin
            p = 0;
            for (int n = 0; n < NV; n++) if (h_bit[c][n]) p ^= dec_bit[n];
            if (p) return 0;
        end
        return 1;
    endfunction

    function automatic void flood_iteration(int levels);
        int tot, v, m1, m2, arg, k;
        bit par;
        for (int n = 0; n < NV; n++) begin
            tot = chan_llr[n];
            for (int c = 0; c < NC; c++) if (h_bit[c][n]) tot += c2v_msg[c][n];
            for (int c = 0; c < NC; c++) begin
                if (!h_bit[c][n]) continue;
                v = tot - c2v_msg[c][n];
                v2c_cnt[c][n] = thermo(v);
                v2c_neg[c][n] = (v < 0);
            end
        end
        for (int c = 0; c < NC; c++) begin
            m1 = levels; m2 = levels; par = 0; arg = -1;
            for (int n = 0; n < NV; n++) begin
                if (!h_bit[c][n]) continue;
                k = v2c_cnt[c][n];
                par ^= v2c_neg[c][n];
                if (k < m1) begin
                    m2 = m1; m1 = k; arg = n;
                end else if (k < m2) begin
                    m2 = k;
                end
            end
            for (int n = 0; n < NV; n++) begin
                if (!h_bit[c][n]) continue;
                k = (n == arg) ? m2 : m1;
                c2v_msg[c][n] = (par ^ v2c_neg[c][n]) ? -k : k;
            end
        end
        for (int n = 0; n < NV; n++) begin
            tot = chan_llr[n];
            for (int c = 0; c < NC; c++) if (h_bit[c][n]) tot += c2v_msg[c][n];
            dec_bit[n] = (tot < 0);
            if (tot > OUT_MAX) tot = OUT_MAX;
            if (tot < OUT_MIN) tot = OUT_MIN;
            post_llr[n] = tot;
        end
    endfunction

    function automatic t_result predict_result(logic [1:0] kind, int row, int pos,
                                               logic [63:0] bits, int llr);
        t_result r;
        int levels, it, total;
        bit ok;
        r = '0;
        case (kind)
            KIND_MATRIX: begin
                if (pos >= (NV + 63) / 64) r.status = 1'b1;
                else for (int k = 0; k < 64; k++)
                    if (pos * 64 + k < NV) h_bit[row][pos * 64 + k] = bits[k];
            end
            KIND_CHANNEL: chan_llr[pos] = int'($signed(llr[LLR_W-1:0]));
            KIND_DECODE: begin
                levels = (cfg_offset < SL) ? SL - cfg_offset : 0;
                it = 0;
                foreach (c2v_msg[c, n]) c2v_msg[c][n] = 0;
                for (int n = 0; n < NV; n++) begin
                    post_llr[n] = chan_llr[n];
                    dec_bit[n] = (chan_llr[n] < 0);
                end
                ok = checks_met();
                while (!ok && it < cfg_max_iter) begin
                    it++;
                    flood_iteration(levels);
                    ok = checks_met();
                end
                total = it * levels;
                if (total > TB_MAX) total = TB_MAX;
                r.converged = ok;
                r.iters = ITER_W'(it);
                r.total = TB_W'(total);
                n_decodes++;
                n_iters += it;
                if (ok) n_converged++;
            end
            default: begin
                r.llr = OUT_W'(post_llr[pos]);
                r.hard = (post_llr[pos] < 0);
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected", $time);
            end else begin
                e = pending_results.pop_front();
                check_field("status", e.status, o_status);
                check_field("converged", e.converged, o_converged);
                check_field("iterations_used", e.iters, o_iterations_used);
                check_field("total_bits", e.total, o_total_bits);
                check_field("llr_out", e.llr, o_llr_out);
                check_field("hard_bit", e.hard, o_hard_bit);
            end
        end
    end

    task automatic send_item(logic [1:0] kind, int row, int pos, logic [63:0] bits,
                             int llr);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_row_index    <= 6'(row);
        i_position     <= 7'(pos);
        i_segment_bits <= bits;
        i_channel_llr  <= LLR_W'(llr);
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_result(kind, row, pos, bits, llr));
        n_items++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_OFFSET) cfg_offset = data & 15;
        else cfg_max_iter = data & 63;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] sparse_bits();
        return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom}
               & {$urandom, $urandom};
    endfunction

    function automatic int rand_llr();
        return (($urandom_range(3) == 0) ? -1 : 1) * $urandom_range(0, 40);
    endfunction

    task automatic test_full_load();
        for (int r = 0; r < NC; r++)
            for (int s = 0; s < 2; s++) send_item(KIND_MATRIX, r, s, sparse_bits(), 0);
        for (int n = 0; n < NV; n++) send_item(KIND_CHANNEL, 0, n, '0, rand_llr());
    endtask

    task automatic test_directed();
        send_item(KIND_MATRIX, 63, 1, '1, 0);
        send_item(KIND_MATRIX, 63, 1, sparse_bits(), 0);
        send_item(KIND_MATRIX, 0, 0, '0, 0);
        send_item(KIND_MATRIX, 0, 0, sparse_bits(), 0);
        send_item(KIND_MATRIX, 5, 2, '1, 0);
        send_item(KIND_MATRIX, 63, 127, '1, 0);
        send_item(KIND_CHANNEL, 0, 0, '0, -2048);
        send_item(KIND_CHANNEL, 0, 127, '0, 2047);
        send_item(KIND_CHANNEL, 0, 1, '0, 0);
        send_item(KIND_CHANNEL, 0, 2, '0, -1);
        send_item(KIND_DECODE, 0, 0, '0, 0);
        send_item(KIND_READ, 0, 0, '0, 0);
        send_item(KIND_READ, 0, 127, '0, 0);
        send_item(KIND_READ, 0, 1, '0, 0);
        send_item(KIND_READ, 0, 2, '0, 0);
        send_item(KIND_READ, 0, 64, '0, 0);
        drain();
    endtask

    task automatic test_config_extremes();
        cfg_write(CFG_OFFSET, 0);
        cfg_write(CFG_MAX_ITER, 0);
        send_item(KIND_DECODE, 0, 0, '0, 0);
        send_item(KIND_READ, 0, 0, '0, 0);
        drain();
        cfg_write(CFG_OFFSET, 15);
        cfg_write(CFG_MAX_ITER, 1);
        send_item(KIND_DECODE, 0, 0, '0, 0);
        send_item(KIND_READ, 0, 3, '0, 0);
        drain();
        cfg_write(CFG_MAX_ITER, 63);
        for (int n = 0; n < NV; n++)
            send_item(KIND_CHANNEL, 0, n, '0, $urandom_range(1, 2047));
        send_item(KIND_DECODE, 0, 0, '0, 0);
        send_item(KIND_READ, 0, 9, '0, 0);
        drain();
    endtask

    task automatic test_random_traffic(int count);
        int sel;
        cfg_write(CFG_OFFSET, $urandom_range(0, 15));
        cfg_write(CFG_MAX_ITER, $urandom_range(1, 3));
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 1)
                send_item(KIND_DECODE, $urandom_range(63), $urandom_range(127),
                          {$urandom, $urandom}, $urandom);
            else if (sel < 30)
                send_item(KIND_MATRIX, $urandom_range(63),
                          ($urandom_range(9) == 0) ? $urandom_range(127)
                                                   : $urandom_range(1),
                          ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                   : sparse_bits(),
                          $urandom);
            else if (sel < 65)
                send_item(KIND_CHANNEL, $urandom_range(63), $urandom_range(127),
                          {$urandom, $urandom},
                          ($urandom_range(4) == 0) ? $urandom_range(0, 4095)
                                                   : rand_llr());
            else
                send_item(KIND_READ, $urandom_range(63), $urandom_range(127),
                          {$urandom, $urandom}, $urandom);
        end
        send_item(KIND_DECODE, 0, 0, '0, 0);
        send_item(KIND_READ, 0, $urandom_range(127), '0, 0);
        drain();
    endtask

    initial begin
        errors = 0; n_items = 0; n_decodes = 0; n_converged = 0; n_iters = 0;
        idle_pct = 0;
        cfg_offset = 2; cfg_max_iter = 20;
        start = 1'b0; i_kind = KIND_MATRIX; i_row_index = '0; i_position = '0;
        i_segment_bits = '0; i_channel_llr = '0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_OFFSET; i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 22;
        test_full_load();
        test_directed();
        test_config_extremes();
        test_random_traffic(64);
        idle_pct = 60;
        test_random_traffic(64);
        idle_pct = 0;
        test_random_traffic(64);

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d transactions, %0d decodes (%0d converged, %0d iterations)",
                 n_items, n_decodes, n_converged, n_iters);
        $display("offset swept 0..15, iteration limit 0..63, bad segment indexes");
        if (errors == 0)
            $display("stochastic_offset_min_sum_ldpc_decoder: match");
        else
            $display("stochastic_offset_min_sum_ldpc_decoder: mismatch");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("timeout");
        $display("stochastic_offset_min_sum_ldpc_decoder: mismatch");
        $finish;
    end

endmodule

// File: files.f
hdl/sold_pkg.sv
hdl/sold_ctrl.sv
hdl/sold_dp.sv
hdl/stochastic_offset_min_sum_ldpc_decoder.sv
bench/tb.sv
